// ----- hw/rtl/bps_pkg.sv -----
package bps_pkg;

   // Width of the time registers; the time counters have one bit more.
   localparam int TIME_BITS  = 16;
   localparam int CNT_W      = TIME_BITS + 1;
   localparam int CSR_DATA_W = 16;
   localparam int REG_W      = (TIME_BITS < CSR_DATA_W) ? TIME_BITS : CSR_DATA_W;
   localparam int CSR_ADDR_W = 3;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [REG_W-1:0]      time_reg_type;

   // Register indexes on the configuration port.
   localparam csr_addr_type CSR_BEEP_ENABLE   = CSR_ADDR_W'(0);
   localparam csr_addr_type CSR_TEST_ENABLE   = CSR_ADDR_W'(1);
   localparam csr_addr_type CSR_SHORT_ON      = CSR_ADDR_W'(2);
   localparam csr_addr_type CSR_LONG_ON       = CSR_ADDR_W'(3);
   localparam csr_addr_type CSR_GAP_OFF       = CSR_ADDR_W'(4);
   localparam csr_addr_type CSR_TEST_INTERVAL = CSR_ADDR_W'(5);

   // Register reset values.
   localparam time_reg_type SHORT_ON_RESET      = REG_W'(50);
   localparam time_reg_type LONG_ON_RESET       = REG_W'(300);
   localparam time_reg_type GAP_OFF_RESET       = REG_W'(80);
   localparam time_reg_type TEST_INTERVAL_RESET = REG_W'(3000);

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_PLAY   = 2'd1,
      OP_FORCE  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PAT_NONE   = 2'd0,
      PAT_SHORT  = 2'd1,
      PAT_DOUBLE = 2'd2,
      PAT_LONG   = 2'd3
   } pattern_type;

   localparam logic [1:0] PULSES_SINGLE = 2'd1;
   localparam logic [1:0] PULSES_DOUBLE = 2'd2;

   typedef struct packed {
      logic         beep_enable;
      logic         test_enable;
      time_reg_type short_on;
      time_reg_type long_on;
      time_reg_type gap_off;
      time_reg_type test_interval;
   } cfg_type;

   typedef struct packed {
      pattern_type pattern;
      op_type      op;
   } item_type;

   typedef struct packed {
      logic [1:0] pulses_left;
      logic       busy_res;
      logic       pin_on;
   } result_type;

   // Counter increment that sticks at all ones.
   function automatic cnt_type sat_inc(input cnt_type value);
      cnt_type result;
      if (value == {CNT_W{1'b1}}) begin
         result = value;
      end else begin
         result = value + CNT_W'(1);
      end
      return result;
   endfunction

endpackage

// ----- hw/rtl/beeper_pattern_sequencer_top.sv -----
// Beeper pattern sequencer.
// The req channel carries one word per 1 ms tick, play or force request; the rsp
// channel returns one word per request word, giving the pin level, the busy
// flag and the pulses still to run after that word.
// The csr port writes a configuration register at any rising edge with csr_we high;
// users must write it only while no word is in flight; the block does not enforce it.
// A word accepted at one edge is registered in the input register, applied
// to the state at an edge where the result register is empty or taken, and its
// result is then offered on rsp from the result register.
// Throughput: one word per cycle while rsp_tready holds high. The state
// update is a single compare and increment path between the two registers.
// When rsp_tready is low the result register holds its word, and an empty
// input register still takes one more word before req_tready falls.
// Reset (synchronous, active high) empties both registers, stops any
// pattern with the pin off, and loads the register defaults: beeper enabled,
// test mode off, 50/300 ms on times, 80 ms gap, 3000 ms test interval.
// The pin_on bit of rsp_tdata is the beeper drive level.
module beeper_pattern_sequencer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // op[1:0], pattern[3:2], zero fill
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // pin_on[0], busy_res[1], pulses_left[3:2]
   input  logic                           csr_we,
   input  bps_pkg::csr_addr_type          csr_addr,
   input  logic [bps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bps_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   result_type step_res;
   cfg_type    cfg;
   logic       test_clear;
   logic       advance;
   logic       step;

   // The result register moves when empty or taken; the input one when empty or with it.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step       = in_valid_ff && advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   bps_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .test_clear (test_clear)
   );

   bps_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .cfg        (cfg),
      .test_clear (test_clear),
      .result     (step_res)
   );

   // Valid flags of the two registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload of the two registers.
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_item_ff <= item_type'(req_tdata[3:0]);
      end
      if (step) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_res_ff};

endmodule

// ----- hw/rtl/bps_csr.sv -----
module bps_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  bps_pkg::csr_addr_type   csr_addr,
   input  logic [bps_pkg::CSR_DATA_W-1:0] csr_wdata,
   output bps_pkg::cfg_type        cfg,
   output logic                    test_clear
);
   import bps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index and update the addressed field.
   always_comb begin
      cfg_in     = cfg_ff;
      test_clear = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_BEEP_ENABLE:   cfg_in.beep_enable = csr_wdata[0];
            CSR_TEST_ENABLE: begin
               cfg_in.test_enable = csr_wdata[0];
               test_clear         = 1'b1;
            end
            CSR_SHORT_ON:      cfg_in.short_on = csr_wdata[REG_W-1:0];
            CSR_LONG_ON:       cfg_in.long_on = csr_wdata[REG_W-1:0];
            CSR_GAP_OFF:       cfg_in.gap_off = csr_wdata[REG_W-1:0];
            CSR_TEST_INTERVAL: cfg_in.test_interval = csr_wdata[REG_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beep_enable   <= 1'b1;
         cfg_ff.test_enable   <= 1'b0;
         cfg_ff.short_on      <= SHORT_ON_RESET;
         cfg_ff.long_on       <= LONG_ON_RESET;
         cfg_ff.gap_off       <= GAP_OFF_RESET;
         cfg_ff.test_interval <= TEST_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/bps_seq.sv -----
module bps_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  bps_pkg::item_type   item,
   input  bps_pkg::cfg_type    cfg,
   input  logic                test_clear,
   output bps_pkg::result_type result
);
   import bps_pkg::*;

   logic       drive_ff, drive_in;
   logic       active_ff, active_in;
   logic [1:0] pulses_ff, pulses_in;
   logic       long_ff, long_in;
   cnt_type    phase_ff, phase_in;
   cnt_type    test_ff, test_in;

   // Next state: a tick advances pattern and test timer; play or force starts one.
   always_comb begin
      time_reg_type on_time;
      logic         start;
      pattern_type  start_pat;

      drive_in  = drive_ff;
      active_in = active_ff;
      pulses_in = pulses_ff;
      long_in   = long_ff;
      phase_in  = phase_ff;
      test_in   = test_ff;
      start     = 1'b0;
      start_pat = item.pattern;
      on_time   = '0;

      if (step) begin
         case (item.op)
            OP_TICK: begin
               phase_in = sat_inc(phase_ff);
               test_in  = sat_inc(test_ff);
               if (cfg.test_enable && !active_ff &&
                   test_in >= CNT_W'(cfg.test_interval)) begin
                  test_in   = '0;
                  start     = 1'b1;
                  start_pat = PAT_SHORT;
               end
            end
            OP_PLAY:  start = cfg.beep_enable && (item.pattern != PAT_NONE);
            OP_FORCE: start = (item.pattern != PAT_NONE);
            default:  start = 1'b0;
         endcase

         // Load a new pattern with the pin on.
         if (start) begin
            pulses_in = (start_pat == PAT_DOUBLE) ? PULSES_DOUBLE : PULSES_SINGLE;
            long_in   = (start_pat == PAT_LONG);
            active_in = 1'b1;
            phase_in  = '0;
            drive_in  = 1'b1;
         end

         // On a tick, an active sequence moves through its on and off phases.
         if (item.op == OP_TICK && active_in) begin
            on_time = long_in ? cfg.long_on : cfg.short_on;
            if (drive_in) begin
               if (phase_in >= CNT_W'(on_time)) begin
                  drive_in = 1'b0;
                  phase_in = '0;
               end
            end else if (phase_in >= CNT_W'(cfg.gap_off)) begin
               if (pulses_in != 2'd0) begin
                  pulses_in = pulses_in - 2'd1;
               end
               if (pulses_in == 2'd0) begin
                  active_in = 1'b0;
               end else begin
                  drive_in = 1'b1;
                  phase_in = '0;
               end
            end
         end
      end

      // A write to the test enable restarts the interval.
      if (test_clear) begin
         test_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff  <= 1'b0;
         active_ff <= 1'b0;
         pulses_ff <= 2'd0;
         long_ff   <= 1'b0;
         phase_ff  <= '0;
         test_ff   <= '0;
      end else begin
         drive_ff  <= drive_in;
         active_ff <= active_in;
         pulses_ff <= pulses_in;
         long_ff   <= long_in;
         phase_ff  <= phase_in;
         test_ff   <= test_in;
      end
   end

   // The result shows the state after this item.
   assign result.pin_on      = drive_in;
   assign result.busy_res    = active_in;
   assign result.pulses_left = pulses_in;

endmodule

// ----- hw/rtl/bps_checker.sv -----
module bps_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // The pin is only driven while a sequence is active.
   a_pin_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> rsp_tdata[1])
      else $error("pin on while no sequence is active");

   // An active sequence always has a pulse to complete.
   a_busy_pulses: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> (rsp_tdata[3:2] != 2'd0))
      else $error("active sequence with no pulses left");

   // No pattern has more than two pulses.
   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:2] != 2'd3))
      else $error("pulse count out of range");

   // A stalled word stays offered.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

endmodule

bind beeper_pattern_sequencer_top bps_checker u_bps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
